// File: hw/rtl/gsr_pkg.sv
// Shared types, constants and the button word loader for the gamepad shift responder.
package gsr_pkg;

  typedef enum logic {
    PAD_NES  = 1'b0,
    PAD_SNES = 1'b1
  } pad_mode_e;

  localparam logic [15:0] NES_IDLE_WORD  = 16'h00FF;
  localparam logic [15:0] SNES_IDLE_WORD = 16'hFFFF;
  localparam logic [4:0]  POS_LIMIT      = 5'd16;
  localparam logic [4:0]  NES_BIT_COUNT  = 5'd8;
  localparam logic [4:0]  SNES_BIT_COUNT = 5'd16;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  // Input item, last field in the lowest bit.
  typedef struct packed {
    logic [11:0] button_mask;
    logic        pad_connected;
    logic        clock_level;
    logic        latch_level;
  } in_item_t;

  // Result item, last field in the lowest bit.
  typedef struct packed {
    logic [4:0] bit_position;
    logic       data_released;
  } out_item_t;

  // Active-low serial word; bit 0 shifts out first.
  function automatic logic [15:0] load_word(pad_mode_e mode, logic connected,
                                            logic [11:0] mask);
    logic [15:0] w;
    if (mode == PAD_NES) begin
      w = NES_IDLE_WORD;
      if (connected) begin
        w[0] = ~mask[0];
        w[1] = ~mask[1];
        w[2] = ~mask[4];
        w[3] = ~mask[5];
        w[4] = ~mask[6];
        w[5] = ~mask[7];
        w[6] = ~mask[8];
        w[7] = ~mask[9];
      end
    end else begin
      w = SNES_IDLE_WORD;
      if (connected) begin
        w[0]  = ~mask[1];
        w[1]  = ~mask[3];
        w[2]  = ~mask[4];
        w[3]  = ~mask[5];
        w[4]  = ~mask[6];
        w[5]  = ~mask[7];
        w[6]  = ~mask[8];
        w[7]  = ~mask[9];
        w[8]  = ~mask[0];
        w[9]  = ~mask[2];
        w[10] = ~mask[10];
        w[11] = ~mask[11];
      end
    end
    return w;
  endfunction

endpackage

// File: hw/rtl/gsr_in_reg.sv
// Input register stage for incoming line samples.
module gsr_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  gsr_pkg::in_item_t s_item_i,
  input  logic              advance_i,
  output logic              valid_o,
  output gsr_pkg::in_item_t item_o
);
  import gsr_pkg::*;

  logic     valid_d, valid_q;
  in_item_t item_q;
  logic     s_fire;

  assign s_ready_o = !valid_q || advance_i;
  assign s_fire    = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (s_fire) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hw/rtl/gsr_core.sv
// Shift register state, mode register and per-sample data line logic.
module gsr_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               fire_i,
  input  gsr_pkg::in_item_t  item_i,
  output gsr_pkg::out_item_t result_o
);
  import gsr_pkg::*;

  pad_mode_e   mode_q;
  logic        resync_d, resync_q;
  logic [15:0] word_d, word_q;
  logic [4:0]  pos_d, pos_q;
  logic        prev_clk_d, prev_clk_q;
  logic        prev_clk_eff;
  logic        reload;
  logic [15:0] new_word;
  logic [4:0]  bit_count;

  assign new_word     = load_word(mode_q, item_i.pad_connected, item_i.button_mask);
  assign prev_clk_eff = resync_q ? item_i.clock_level : prev_clk_q;
  assign reload       = resync_q || item_i.latch_level;
  assign bit_count    = (mode_q == PAD_NES) ? NES_BIT_COUNT : SNES_BIT_COUNT;

  always_comb begin
    word_d     = word_q;
    pos_d      = pos_q;
    prev_clk_d = prev_clk_q;
    resync_d   = resync_q;
    if (fire_i) begin
      prev_clk_d = item_i.clock_level;
      resync_d   = 1'b0;
      if (reload) begin
        word_d = new_word;
        pos_d  = '0;
      end else if (item_i.clock_level && !prev_clk_eff && (pos_q < POS_LIMIT)) begin
        pos_d = pos_q + 5'd1;
      end
    end
    if (cfg_we_i && (pad_mode_e'(cfg_wdata_i) != mode_q)) begin
      resync_d = 1'b1;
    end
  end

  always_comb begin
    result_o.bit_position  = pos_d;
    result_o.data_released = (pos_d < bit_count) ? word_d[pos_d[3:0]] : 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= PAD_NES;
      resync_q   <= 1'b1;
      word_q     <= SNES_IDLE_WORD;
      pos_q      <= '0;
      prev_clk_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= pad_mode_e'(cfg_wdata_i);
      end
      resync_q   <= resync_d;
      word_q     <= word_d;
      pos_q      <= pos_d;
      prev_clk_q <= prev_clk_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_LIMIT)
    else $error("shift position out of range");

  a_latch_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.latch_level |=> pos_q == 5'd0)
    else $error("latch did not clear position");

  a_mode_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (pad_mode_e'(cfg_wdata_i) != mode_q) |=> resync_q)
    else $error("mode change did not request resync");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(pos_q))
    else $error("position moved without a transaction");

endmodule

// File: hw/rtl/gsr_out_reg.sv
// Result register stage toward the master side.
module gsr_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  gsr_pkg::out_item_t item_i,
  output logic               advance_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output gsr_pkg::out_item_t m_item_o
);
  import gsr_pkg::*;

  logic      valid_d, valid_q;
  out_item_t item_q;

  assign advance_o = !valid_q || m_ready_i;
  assign valid_d   = advance_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_item_o  = item_q;

endmodule

// File: hw/rtl/gamepad_serial_shift_responder.sv
// Top level of the gamepad serial shift responder.
// Slave stream: one transaction per sample of the console latch and clock lines,
// carrying the pad's button mask and connected flag. Master stream: one
// transaction per sample with the data line level and the shift position.
// cfg_we_i/cfg_wdata_i write the pad mode (0 NES, 1 SNES); write only while idle.
// A sample accepted into the input register passes through the shift logic into the
// output register once that register can take it; m_axis_tvalid_o is driven from it.
// Throughput: one transaction per cycle while the receiver does not stall; the shift
// state update is a single pass of logic between the input register and the result register.
// Reset: pad mode NES, word all released, position zero, and the first sample
// after reset resynchronizes without seeing an edge.
// When the receiver stalls, the result register holds and the input register
// still takes one more sample; s_axis_tready_o drops once both are full.
module gamepad_serial_shift_responder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [0] latch_level, [1] clock_level, [2] pad_connected, [14:3] button_mask
  input  logic [gsr_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] data_released, [5:1] bit_position
  output logic [gsr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);
  import gsr_pkg::*;

  in_item_t  s_item, in_item;
  out_item_t core_result, out_item;
  logic      in_valid, advance, fire;

  assign s_item = in_item_t'(s_axis_tdata_i[$bits(in_item_t)-1:0]);
  assign fire   = in_valid && advance;

  gsr_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_item_i  (s_item),
    .advance_i (advance),
    .valid_o   (in_valid),
    .item_o    (in_item)
  );

  gsr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (in_item),
    .result_o    (core_result)
  );

  gsr_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid),
    .item_i    (core_result),
    .advance_o (advance),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_item_o  (out_item)
  );

  assign m_axis_tdata_o = {{(OUT_TDATA_W-$bits(out_item_t)){1'b0}}, out_item};

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for gamepad_serial_shift_responder: pad frames, noise and mode changes.
module tb;
  import gsr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 210;
  localparam int unsigned MAX_REPORTS    = 10;
  // button index per shift position, one nibble per position, position 0 lowest
  localparam logic [31:0] NES_ORDER  = 32'h9876_5410;
  localparam logic [47:0] SNES_ORDER = 48'hBA20_9876_5431;
  // pad mode of the first phases: NES, SNES, SNES again, NES
  localparam logic [3:0]  MODE_PLAN  = 4'b0110;

  class pad_shift_scoreboard;
    pad_mode_e   mode;
    logic [15:0] shift_word;
    logic [4:0]  position;
    logic        last_clock;
    logic        resync;
    out_item_t   expected_line_q[$];
    int unsigned mismatches;

    function new();
      mode       = PAD_NES;
      shift_word = 16'hFFFF;
      position   = '0;
      last_clock = 1'b0;
      resync     = 1'b1;
      mismatches = 0;
    endfunction

    function void write_mode(pad_mode_e m);
      if (m != mode) begin
        resync = 1'b1;
      end
      mode = m;
    endfunction

    function logic [15:0] serial_word(logic connected, logic [11:0] mask);
      logic [15:0] w;
      w = (mode == PAD_NES) ? NES_IDLE_WORD : SNES_IDLE_WORD;
      if (connected) begin
        if (mode == PAD_NES) begin
          for (int i = 0; i < 8; i++) begin
            if (mask[NES_ORDER[4*i +: 4]]) w[i] = 1'b0;
          end
        end else begin
          for (int i = 0; i < 12; i++) begin
            if (mask[SNES_ORDER[4*i +: 4]]) w[i] = 1'b0;
          end
        end
      end
      return w;
    endfunction

    // Accepted sample: advance the shift state and queue the data line it gives.
    function void take_sample(in_item_t s);
      out_item_t  line;
      logic [4:0] count;
      count = (mode == PAD_NES) ? NES_BIT_COUNT : SNES_BIT_COUNT;
      if (resync) begin
        last_clock = s.clock_level;
        position   = '0;
        shift_word = serial_word(s.pad_connected, s.button_mask);
        resync     = 1'b0;
      end
      if (s.latch_level) begin
        shift_word = serial_word(s.pad_connected, s.button_mask);
        position   = '0;
      end else if (s.clock_level && !last_clock && position < POS_LIMIT) begin
        position = position + 5'd1;
      end
      last_clock         = s.clock_level;
      line.bit_position  = position;
      line.data_released = (position < count) ? shift_word[position[3:0]] : 1'b1;
      expected_line_q.push_back(line);
    endfunction

    function void check_line(logic [OUT_TDATA_W-1:0] raw);
      out_item_t got;
      out_item_t want;
      got = out_item_t'(raw[$bits(out_item_t)-1:0]);
      if (expected_line_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: released=%0d pos=%0d",
                   got.data_released, got.bit_position);
        end
        return;
      end
      want = expected_line_q.pop_front();
      if (got.data_released !== want.data_released ||
          got.bit_position !== want.bit_position) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch: expected released=%0d pos=%0d, got released=%0d pos=%0d",
                   want.data_released, want.bit_position, got.data_released, got.bit_position);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_line_q.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we;
  logic                   cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned items_sent = 0;
  bit          hold_req = 1'b0;

  pad_shift_scoreboard sb;

  gamepad_serial_shift_responder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic in_item_t sample(logic latch, logic clock, logic connected,
                                      logic [11:0] mask);
    in_item_t it;
    it.latch_level   = latch;
    it.clock_level   = clock;
    it.pad_connected = connected;
    it.button_mask   = mask;
    return it;
  endfunction

  function automatic int unsigned idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 5;
      default: return 20;
    endcase
  endfunction

  task automatic send_sample(input in_item_t item);
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(item);
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.take_sample(item);
    items_sent++;
  endtask

  task automatic offer(input in_item_t item);
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    send_sample(item);
  endtask

  // Latch pulse, then clock pulses; pulse count runs past 16 to hit saturation.
  task automatic run_frame();
    logic        connected;
    int unsigned pulses;
    connected = ($urandom_range(0, 9) != 0);
    pulses    = $urandom_range(0, 20);
    repeat ($urandom_range(1, 3)) begin
      offer(sample(1'b1, 1'($urandom_range(0, 1)), connected, 12'($urandom_range(0, 4095))));
    end
    repeat (pulses) begin
      repeat ($urandom_range(1, 3)) offer(sample(1'b0, 1'b0, connected, 12'($urandom)));
      repeat ($urandom_range(1, 3)) offer(sample(1'b0, 1'b1, connected, 12'($urandom)));
    end
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 8)) offer(in_item_t'(15'($urandom_range(0, 32767))));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_pad_mode(input pad_mode_e m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.write_mode(m);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      sb.check_line(m_tdata);
    end
  end

  initial begin : receiver
    m_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL gamepad_serial_shift_responder");
    $finish;
  end

  initial begin : main_seq
    pad_mode_e   phase_mode;
    int unsigned phase_end;
    sb = new();
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // NES: resync after reset with clock high, edges, clock edge under latch, unplugged pad
    send_sample(sample(1'b0, 1'b1, 1'b1, 12'hFFF));
    send_sample(sample(1'b0, 1'b1, 1'b1, 12'hFFF));
    send_sample(sample(1'b0, 1'b0, 1'b1, 12'hFFF));
    send_sample(sample(1'b0, 1'b1, 1'b1, 12'hFFF));
    send_sample(sample(1'b1, 1'b0, 1'b1, 12'h000));
    send_sample(sample(1'b1, 1'b1, 1'b1, 12'h001));
    send_sample(sample(1'b0, 1'b0, 1'b1, 12'hFFF));
    send_sample(sample(1'b0, 1'b1, 1'b1, 12'h000));
    send_sample(sample(1'b1, 1'b0, 1'b0, 12'hFFF));
    send_sample(sample(1'b0, 1'b1, 1'b0, 12'hFFF));
    drain();
    // SNES: mode change resyncs on a latch sample with clock high
    write_pad_mode(PAD_SNES);
    send_sample(sample(1'b1, 1'b1, 1'b1, 12'hFFF));
    send_sample(sample(1'b0, 1'b0, 1'b1, 12'h000));
    send_sample(sample(1'b0, 1'b1, 1'b1, 12'h000));
    send_sample(sample(1'b0, 1'b0, 1'b1, 12'h000));
    send_sample(sample(1'b0, 1'b1, 1'b1, 12'h000));
    send_sample(sample(1'b1, 1'b0, 1'b0, 12'h000));
    drain();
    // same mode again: no resync, so the next clock rise is an edge
    write_pad_mode(PAD_SNES);
    send_sample(sample(1'b0, 1'b1, 1'b1, 12'h000));
    send_sample(sample(1'b1, 1'b0, 1'b1, 12'h800));
    send_sample(sample(1'b0, 1'b0, 1'b1, 12'h400));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      phase_mode = (p < 4) ? pad_mode_e'(MODE_PLAN[p]) : pad_mode_e'($urandom_range(0, 1));
      write_pad_mode(phase_mode);
      if (p == PHASES - 1) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct   = idle_pct();
        rx_stall_pct = idle_pct();
      end
      if (p == 2) hold_req = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) != 0) run_frame();
        else run_noise();
      end
    end

    drain();
    repeat (5) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS gamepad_serial_shift_responder");
    end else begin
      $display("FAIL gamepad_serial_shift_responder");
    end
    $finish;
  end

endmodule
